### src/sab_pkg.sv
// package for the suffix automaton builder
// word types, status codes and size defaults; no dependencies
package sab_pkg;

	localparam int MAX_STATES_DEF    = 2048;
	localparam int ALPHABET_SIZE_DEF = 26;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NONE  = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [4:0]  symbol;
		logic [10:0] from_state;
	} cmd_t;

	typedef struct packed {
		status_t     status;
		logic [10:0] next_state;
		logic [10:0] last_state;
		logic [11:0] state_count;
	} rsp_t;

endpackage

### src/sab_ram.sv
// simple dual port synchronous ram, one write port and one registered read port
// no dependencies
module sab_ram #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 12
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/suffix_automaton_builder.sv
// suffix automaton builder top level: sequencer around the transition and node memories
// depends on sab_pkg and sab_ram
//
// usage: drive cmd and raise start; the word is taken at a clock edge where start is
// high and busy is low. every command gives one response word on rsp, marked by done
// for exactly one cycle; the receiver cannot stall it.
// a query whose state is out of range or whose symbol is outside the alphabet, and an
// append that is refused, answer on the cycle after acceptance and keep busy low.
// a valid query passes through the multiply, read and check states with busy high.
// an append holds busy through setup (length read, multiply), the clear of the new row,
// and a suffix link walk of multiply, read and check per step, then finish; a walk that
// stops on an existing transition also reads that node, and a clone copies its row with
// one read and one write per entry in turn. done follows the last busy cycle.
// after reset the root row (ALPHABET_SIZE entries) is cleared one entry a cycle while
// busy is high.
module suffix_automaton_builder #(
	parameter int MAX_STATES    = sab_pkg::MAX_STATES_DEF,
	parameter int ALPHABET_SIZE = sab_pkg::ALPHABET_SIZE_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  sab_pkg::cmd_t cmd,
	output logic          done,
	output sab_pkg::rsp_t rsp
);

	import sab_pkg::*;

	localparam int SW = $clog2(MAX_STATES);
	localparam int CW = SW + 1;
	localparam int AW = $clog2(MAX_STATES * ALPHABET_SIZE);
	localparam int IW = $clog2(ALPHABET_SIZE);
	localparam int TW = 1 + SW;
	localparam int NW = 1 + 2 * SW;

	typedef enum logic [18:0] {
		S_INIT  = 19'h00001,
		S_IDLE  = 19'h00002,
		S_QMUL  = 19'h00004,
		S_QRD   = 19'h00008,
		S_QCHK  = 19'h00010,
		S_ALEN  = 19'h00020,
		S_AMUL  = 19'h00040,
		S_ACLR  = 19'h00080,
		S_WMUL  = 19'h00100,
		S_WRD   = 19'h00200,
		S_WCHK  = 19'h00400,
		S_NRD   = 19'h00800,
		S_NCHK  = 19'h01000,
		S_CMUL  = 19'h02000,
		S_CMUL2 = 19'h04000,
		S_CRD   = 19'h08000,
		S_CWR   = 19'h10000,
		S_FINQ  = 19'h20000,
		S_DONE  = 19'h40000
	} state_t;

	state_t        state_q;
	logic [SW-1:0] last_q, cur_q, p_q, q_q, cl_q, from_q;
	logic [CW-1:0] used_q;
	logic [4:0]    sym_q;
	logic [SW-1:0] len_cur_q, len_p_q, len_q_q;
	logic [AW-1:0] base_q, dst_q;
	logic [IW-1:0] idx_q;
	logic          phase_q;
	logic          done_q;
	rsp_t          rsp_q;

	logic          tt_we, tt_re, nd_we, nd_re;
	logic [AW-1:0] tt_waddr, tt_raddr;
	logic [TW-1:0] tt_wdata, tt_rdata;
	logic [SW-1:0] nd_waddr, nd_raddr;
	logic [NW-1:0] nd_wdata, nd_raw, nd_rdata;
	logic          nd_root_q;
	logic [SW-1:0] mul_in;
	logic [AW-1:0] mul_out, walk_addr;
	logic          tt_ok;
	logic [SW-1:0] tt_tgt;
	logic          lk_ok;
	logic [SW-1:0] lk_tgt, nd_len;
	logic          idx_end;

	sab_ram #(.DEPTH(MAX_STATES * ALPHABET_SIZE), .WIDTH(TW)) u_trans (
		.clk(clk), .we(tt_we), .waddr(tt_waddr), .wdata(tt_wdata),
		.re(tt_re), .raddr(tt_raddr), .rdata(tt_rdata)
	);

	sab_ram #(.DEPTH(MAX_STATES), .WIDTH(NW)) u_node (
		.clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
		.re(nd_re), .raddr(nd_raddr), .rdata(nd_raw)
	);

	// root node has no link and zero length
	assign nd_rdata = nd_root_q ? '0 : nd_raw;
	assign {lk_ok, lk_tgt, nd_len} = nd_rdata;
	assign {tt_ok, tt_tgt} = tt_rdata;

	always_comb begin
		case (state_q)
			S_AMUL:  mul_in = cur_q;
			S_CMUL:  mul_in = q_q;
			S_CMUL2: mul_in = cl_q;
			S_QMUL:  mul_in = from_q;
			default: mul_in = p_q;
		endcase
	end

	assign mul_out   = AW'(mul_in) * AW'(ALPHABET_SIZE);
	assign walk_addr = base_q + AW'(sym_q);
	assign idx_end   = (idx_q == IW'(ALPHABET_SIZE - 1));

	always_comb begin
		tt_we    = 1'b0;
		tt_waddr = walk_addr;
		tt_wdata = '0;
		tt_re    = 1'b0;
		tt_raddr = walk_addr;
		nd_we    = 1'b0;
		nd_waddr = cur_q;
		nd_wdata = '0;
		nd_re    = 1'b0;
		nd_raddr = p_q;
		case (state_q)
			S_INIT: begin
				tt_we    = 1'b1;
				tt_waddr = AW'(idx_q);
			end
			S_QRD, S_WRD: begin
				tt_re = 1'b1;
				nd_re = (state_q == S_WRD);
			end
			S_ALEN: begin
				nd_re    = 1'b1;
				nd_raddr = last_q;
			end
			S_ACLR: begin
				tt_we    = 1'b1;
				tt_waddr = base_q + AW'(idx_q);
			end
			S_WCHK: begin
				if (!phase_q) begin
					if (!tt_ok) begin
						tt_we    = 1'b1;
						tt_wdata = {1'b1, cur_q};
					end else begin
						nd_we = 1'b0;
					end
					if (!tt_ok && !lk_ok) begin
						nd_we    = 1'b1;
						nd_wdata = {1'b1, SW'(0), len_cur_q};
					end
				end else if (tt_ok && tt_tgt == q_q) begin
					tt_we    = 1'b1;
					tt_wdata = {1'b1, cl_q};
				end
			end
			S_NRD: begin
				nd_re    = 1'b1;
				nd_raddr = q_q;
			end
			S_NCHK: begin
				nd_we = 1'b1;
				if (len_p_q + SW'(1) == nd_len) begin
					nd_wdata = {1'b1, q_q, len_cur_q};
				end else begin
					nd_waddr = SW'(used_q);
					nd_wdata = {lk_ok, lk_tgt, len_p_q + SW'(1)};
				end
			end
			S_CRD: begin
				tt_re    = 1'b1;
				tt_raddr = base_q + AW'(idx_q);
			end
			S_CWR: begin
				tt_we    = 1'b1;
				tt_waddr = dst_q + AW'(idx_q);
				tt_wdata = tt_rdata;
			end
			S_FINQ: begin
				nd_we    = 1'b1;
				nd_waddr = q_q;
				nd_wdata = {1'b1, cl_q, len_q_q};
			end
			S_DONE: begin
				if (phase_q) begin
					nd_we    = 1'b1;
					nd_wdata = {1'b1, cl_q, len_cur_q};
				end
			end
			default: begin
				tt_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			last_q    <= '0;
			used_q    <= CW'(1);
			idx_q     <= '0;
			phase_q   <= 1'b0;
			done_q    <= 1'b0;
			nd_root_q <= 1'b0;
			cur_q     <= '0;
			p_q       <= '0;
			q_q       <= '0;
			cl_q      <= '0;
			from_q    <= '0;
			sym_q     <= '0;
			len_cur_q <= '0;
			len_p_q   <= '0;
			len_q_q   <= '0;
			base_q    <= '0;
			dst_q     <= '0;
			rsp_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (nd_re) begin
				nd_root_q <= (nd_raddr == '0);
			end
			case (state_q)
				S_INIT: begin
					idx_q <= idx_q + IW'(1);
					if (idx_end) begin
						idx_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						sym_q              <= cmd.symbol;
						from_q             <= SW'(cmd.from_state);
						rsp_q.next_state   <= '0;
						rsp_q.last_state   <= 11'(last_q);
						rsp_q.state_count  <= 12'(used_q);
						phase_q            <= 1'b0;
						if (cmd.operation == OP_QUERY) begin
							if (32'(cmd.from_state) >= 32'(used_q)) begin
								rsp_q.status <= ST_RANGE;
								done_q       <= 1'b1;
							end else if (32'(cmd.symbol) >= ALPHABET_SIZE) begin
								rsp_q.status <= ST_NONE;
								done_q       <= 1'b1;
							end else begin
								state_q <= S_QMUL;
							end
						end else begin
							if (32'(cmd.symbol) >= ALPHABET_SIZE) begin
								rsp_q.status <= ST_RANGE;
								done_q       <= 1'b1;
							end else if (32'(used_q) > MAX_STATES - 2) begin
								rsp_q.status <= ST_FULL;
								done_q       <= 1'b1;
							end else begin
								cur_q   <= SW'(used_q);
								used_q  <= used_q + CW'(1);
								p_q     <= last_q;
								state_q <= S_ALEN;
							end
						end
					end
				end
				S_QMUL: begin
					base_q  <= mul_out;
					state_q <= S_QRD;
				end
				S_QRD: begin
					state_q <= S_QCHK;
				end
				S_QCHK: begin
					rsp_q.status     <= tt_ok ? ST_OK : ST_NONE;
					rsp_q.next_state <= tt_ok ? 11'(tt_tgt) : '0;
					done_q           <= 1'b1;
					state_q          <= S_IDLE;
				end
				S_ALEN: begin
					state_q <= S_AMUL;
				end
				S_AMUL: begin
					len_cur_q <= nd_len + SW'(1);
					base_q    <= mul_out;
					idx_q     <= '0;
					state_q   <= S_ACLR;
				end
				S_ACLR: begin
					idx_q <= idx_q + IW'(1);
					if (idx_end) begin
						idx_q   <= '0;
						state_q <= S_WMUL;
					end
				end
				S_WMUL: begin
					base_q  <= mul_out;
					state_q <= S_WRD;
				end
				S_WRD: begin
					state_q <= S_WCHK;
				end
				S_WCHK: begin
					if (!phase_q) begin
						if (!tt_ok) begin
							p_q     <= lk_tgt;
							state_q <= lk_ok ? S_WMUL : S_DONE;
						end else begin
							q_q     <= tt_tgt;
							len_p_q <= nd_len;
							state_q <= S_NRD;
						end
					end else if (tt_ok && tt_tgt == q_q) begin
						p_q     <= lk_tgt;
						state_q <= lk_ok ? S_WMUL : S_FINQ;
					end else begin
						state_q <= S_FINQ;
					end
				end
				S_NRD: begin
					state_q <= S_NCHK;
				end
				S_NCHK: begin
					if (len_p_q + SW'(1) == nd_len) begin
						state_q <= S_DONE;
					end else begin
						len_q_q <= nd_len;
						cl_q    <= SW'(used_q);
						used_q  <= used_q + CW'(1);
						state_q <= S_CMUL;
					end
				end
				S_CMUL: begin
					base_q  <= mul_out;
					state_q <= S_CMUL2;
				end
				S_CMUL2: begin
					dst_q   <= mul_out;
					idx_q   <= '0;
					state_q <= S_CRD;
				end
				S_CRD: begin
					state_q <= S_CWR;
				end
				S_CWR: begin
					idx_q <= idx_q + IW'(1);
					if (idx_end) begin
						idx_q   <= '0;
						phase_q <= 1'b1;
						state_q <= S_WMUL;
					end else begin
						state_q <= S_CRD;
					end
				end
				S_FINQ: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					last_q            <= cur_q;
					rsp_q.status      <= ST_OK;
					rsp_q.next_state  <= '0;
					rsp_q.last_state  <= 11'(cur_q);
					rsp_q.state_count <= 12'(used_q);
					done_q            <= 1'b1;
					state_q           <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("sequencer state not one-hot");

	a_used_max: assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_q) <= MAX_STATES) else $error("state count beyond table");

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done)) else $error("accepted word lost");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!tt_we && !nd_we)) else $error("write while idle");

endmodule

### tb/sab_checker.sv
// checker for the suffix automaton builder: watches the command and response words,
// keeps its own copy of the automaton and compares every response; depends on sab_pkg
`timescale 1ns / 1ps
module sab_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  sab_pkg::cmd_t cmd,
	input  logic          done,
	input  sab_pkg::rsp_t rsp,
	output int            fails,
	output int            pending
);
	import sab_pkg::*;

	localparam int NST = MAX_STATES_DEF;
	localparam int NSYM = ALPHABET_SIZE_DEF;

	logic [10:0] edge_to [0:NST*NSYM-1];
	bit          edge_ok [0:NST*NSYM-1];
	logic [10:0] link_to [0:NST-1];
	bit          link_ok [0:NST-1];
	int          depth_of [0:NST-1];
	int          tail_state;
	int          states_used;
	rsp_t        rsp_fifo [16];
	logic [3:0]  wr_ptr = '0;
	logic [3:0]  rd_ptr = '0;
	int          fifo_count = 0;
	int          fail_count = 0;

	task automatic clear_automaton();
		for (int i = 0; i < NST*NSYM; i++) begin
			edge_ok[i] = 0;
			edge_to[i] = '0;
		end
		for (int i = 0; i < NST; i++) begin
			link_ok[i] = 0;
			link_to[i] = '0;
			depth_of[i] = 0;
		end
		tail_state = 0;
		states_used = 1;
	endtask

	task automatic extend_automaton(input int s);
		int cur, p, q, cl;
		bit walking;
		cur = states_used;
		p = tail_state;
		walking = 1;
		states_used++;
		depth_of[cur] = depth_of[tail_state] + 1;
		for (int k = 0; k < NSYM; k++) begin
			edge_ok[cur*NSYM+k] = 0;
			edge_to[cur*NSYM+k] = '0;
		end
		while (walking && !edge_ok[p*NSYM+s]) begin
			edge_ok[p*NSYM+s] = 1;
			edge_to[p*NSYM+s] = 11'(cur);
			if (link_ok[p]) p = int'(link_to[p]);
			else walking = 0;
		end
		link_ok[cur] = 1;
		if (!walking) begin
			link_to[cur] = '0;
		end else begin
			q = int'(edge_to[p*NSYM+s]);
			if (depth_of[p] + 1 == depth_of[q]) begin
				link_to[cur] = 11'(q);
			end else begin
				cl = states_used;
				states_used++;
				for (int k = 0; k < NSYM; k++) begin
					edge_to[cl*NSYM+k] = edge_to[q*NSYM+k];
					edge_ok[cl*NSYM+k] = edge_ok[q*NSYM+k];
				end
				link_to[cl] = link_to[q];
				link_ok[cl] = link_ok[q];
				depth_of[cl] = depth_of[p] + 1;
				while (walking && edge_ok[p*NSYM+s] && int'(edge_to[p*NSYM+s]) == q) begin
					edge_to[p*NSYM+s] = 11'(cl);
					if (link_ok[p]) p = int'(link_to[p]);
					else walking = 0;
				end
				link_to[q] = 11'(cl);
				link_ok[q] = 1;
				link_to[cur] = 11'(cl);
			end
		end
		tail_state = cur;
	endtask

	task automatic store_expected(input rsp_t r);
		rsp_fifo[wr_ptr] = r;
		wr_ptr = wr_ptr + 4'd1;
		fifo_count++;
	endtask

	task automatic predict_response(input cmd_t c);
		rsp_t r;
		r.status = ST_OK;
		r.next_state = '0;
		if (c.operation == OP_APPEND) begin
			if (c.symbol >= NSYM) r.status = ST_RANGE;
			else if (states_used > NST - 2) r.status = ST_FULL;
			else extend_automaton(int'(c.symbol));
		end else begin
			if (c.from_state >= states_used) r.status = ST_RANGE;
			else if (c.symbol >= NSYM || !edge_ok[c.from_state*NSYM+c.symbol])
				r.status = ST_NONE;
			else r.next_state = edge_to[c.from_state*NSYM+c.symbol];
		end
		r.last_state = tail_state[10:0];
		r.state_count = states_used[11:0];
		store_expected(r);
	endtask

	assign pending = fifo_count;
	assign fails = fail_count;

	always @(posedge clk) begin
		rsp_t want;
		if (!arst_n) begin
			clear_automaton();
			wr_ptr = '0;
			rd_ptr = '0;
			fifo_count = 0;
		end else begin
			if (done) begin
				if (fifo_count == 0) begin
					fail_count++;
					if (fail_count <= 10) $display("unexpected response word %h", rsp);
				end else begin
					want = rsp_fifo[rd_ptr];
					rd_ptr = rd_ptr + 4'd1;
					fifo_count--;
					if (rsp.status !== want.status || rsp.next_state !== want.next_state ||
							rsp.last_state !== want.last_state ||
							rsp.state_count !== want.state_count) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"mismatch: expected st=%0d nxt=%0d last=%0d cnt=%0d,",
								" got st=%0d nxt=%0d last=%0d cnt=%0d"},
								want.status, want.next_state, want.last_state,
								want.state_count, rsp.status, rsp.next_state,
								rsp.last_state, rsp.state_count);
					end
				end
			end
			if (start && !busy) predict_response(cmd);
		end
	end
endmodule

### tb/tb.sv
// top of the suffix automaton builder testbench: clock, reset, command stimulus and verdict
// depends on sab_pkg, sab_checker and the builder rtl
`timescale 1ns / 1ps
module tb;
	import sab_pkg::*;

	logic  clk = 0;
	logic  arst_n = 0;
	logic  start = 0;
	logic  busy;
	logic  done;
	cmd_t  cmd = '0;
	rsp_t  rsp;
	int    fails;
	int    pending;
	int    known_states = 1;
	int    idle_cycles = 0;
	int    n_append = 0;
	int    n_query = 0;
	int    n_full = 0;
	bit    full_seen = 0;
	bit    no_idle = 0;

	suffix_automaton_builder DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .rsp(rsp)
	);

	sab_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .rsp(rsp), .fails(fails), .pending(pending)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles = 0;
		else idle_cycles++;
		if (done) begin
			known_states = int'(rsp.state_count);
			if (rsp.status == ST_FULL) begin
				full_seen = 1;
				n_full++;
			end
		end
		if (idle_cycles > 50000) begin
			$display("FAIL suffix_automaton_builder");
			$finish;
		end
	end

	task automatic send_word(input logic op, input logic [4:0] sym, input logic [10:0] from);
		@(negedge clk);
		if (!no_idle && $urandom_range(0, 99) < 33) begin
			start <= 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		cmd.operation <= op;
		cmd.symbol <= sym;
		cmd.from_state <= from;
		start <= 1;
		do @(posedge clk); while (busy);
		if (op == OP_APPEND) n_append++;
		else n_query++;
	endtask

	task automatic random_word(input bit fill);
		logic [4:0] sym;
		logic [10:0] from;
		if ($urandom_range(0, 99) < 80) sym = 5'($urandom_range(0, 3));
		else if ($urandom_range(0, 9) < 8) sym = 5'($urandom_range(0, 25));
		else sym = 5'($urandom_range(26, 31));
		if ($urandom_range(0, 9) < 8) from = 11'($urandom_range(0, known_states - 1));
		else from = 11'($urandom);
		if (fill || $urandom_range(0, 99) < 88) send_word(OP_APPEND, sym, from);
		else send_word(OP_QUERY, sym, from);
	endtask

	initial begin
		int waited;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		send_word(OP_QUERY, 5'd0, 11'd0);
		send_word(OP_QUERY, 5'd25, 11'd2047);
		send_word(OP_APPEND, 5'd31, 11'd2047);
		send_word(OP_APPEND, 5'd26, 11'd0);
		send_word(OP_APPEND, 5'd0, 11'd0);
		send_word(OP_APPEND, 5'd1, 11'd0);
		send_word(OP_APPEND, 5'd0, 11'd0);
		send_word(OP_APPEND, 5'd1, 11'd0);
		send_word(OP_APPEND, 5'd1, 11'd0);
		send_word(OP_APPEND, 5'd25, 11'd0);
		send_word(OP_QUERY, 5'd0, 11'd0);
		send_word(OP_QUERY, 5'd1, 11'd1);
		send_word(OP_QUERY, 5'd25, 11'd0);
		send_word(OP_QUERY, 5'd31, 11'd0);
		send_word(OP_QUERY, 5'd2, 11'd3);
		send_word(OP_QUERY, 5'd0, 11'd2047);
		send_word(OP_QUERY, 5'd0, 11'd1024);
		for (int i = 0; i < 1450; i++) begin
			no_idle = (i >= 500 && i < 700);
			random_word(0);
		end
		no_idle = 0;
		while (!full_seen) random_word(1);
		for (int i = 0; i < 30; i++) random_word(0);
		@(negedge clk);
		start <= 0;
		waited = 0;
		while (pending != 0 && waited < 50000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		$display("covered %0d appends and %0d queries, %0d refused as full",
			n_append, n_query, n_full);
		if (fails == 0 && pending == 0) begin
			$display("PASS suffix_automaton_builder");
		end else begin
			$display("FAIL suffix_automaton_builder");
		end
		$finish;
	end
endmodule
